FILE: rtl/ptc_pkg.sv
// Shared types and constants for the plane triangle clipper.
package ptc_pkg;

    localparam int COORD_W = 32;
    localparam int QUO_W   = 32;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [COORD_W:0]          mag_t;

    typedef enum logic [1:0] {
        REG_NORMAL_X     = 2'd0,
        REG_NORMAL_Y     = 2'd1,
        REG_NORMAL_Z     = 2'd2,
        REG_PLANE_OFFSET = 2'd3
    } cfg_reg_t;

    // Source of one output vertex: an original vertex or one of two crossings
    typedef enum logic [2:0] {
        SRC_P0 = 3'd0,
        SRC_P1 = 3'd1,
        SRC_P2 = 3'd2,
        SRC_X0 = 3'd3,
        SRC_X1 = 3'd4
    } src_t;

    localparam coord_t NORMAL_X_RESET = 32'sh0000_0000;
    localparam coord_t NORMAL_Y_RESET = 32'sh0000_0000;
    localparam coord_t NORMAL_Z_RESET = 32'sh0001_0000;
    localparam coord_t OFFSET_RESET   = 32'sh0000_0000;

    typedef struct packed {
        logic                   valid;
        logic [2:0]             cnt;
        src_t [3:0]             src;
        coord_t [2:0][2:0]      p;
        coord_t [1:0][2:0]      xa;
        logic [1:0][2:0]        neg;
        mag_t [1:0][2:0]        mag;
    } ctx_t;

    typedef struct packed {
        logic                   valid;
        logic [2:0]             cnt;
        coord_t [3:0][2:0]      vtx;
        logic [3:0]             crossing;
    } grp_t;

endpackage

FILE: rtl/plane_triangle_clipper.sv
// Top level: clips one triangle per item against a configured plane.
// A triangle passes stages 1-4, the dividers and stages 5-6 before the output sequencer.
// Throughput: one triangle per cycle enters while in_stall is low; the output emits one
// vertex per cycle while out_stall is low; the result port sets the pace of the pipe.
// The two crossing fractions come from two 32-stage divider pipelines.
// Reset clears all valid bits and loads the plane registers (normal 0,0,1.0; offset 0).
module plane_triangle_clipper (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [31:0]  first_x,
    input  logic signed [31:0]  first_y,
    input  logic signed [31:0]  first_z,
    input  logic signed [31:0]  second_x,
    input  logic signed [31:0]  second_y,
    input  logic signed [31:0]  second_z,
    input  logic signed [31:0]  third_x,
    input  logic signed [31:0]  third_y,
    input  logic signed [31:0]  third_z,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  vertex_x,
    output logic signed [31:0]  vertex_y,
    output logic signed [31:0]  vertex_z,
    output logic [2:0]          polygon_size,
    output logic                is_crossing,
    output logic                last_vertex
);

    localparam int DivDepth = ptc_pkg::QUO_W;

    // plane registers
    ptc_pkg::coord_t nx_reg, ny_reg, nz_reg, d_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg <= ptc_pkg::NORMAL_X_RESET;
            ny_reg <= ptc_pkg::NORMAL_Y_RESET;
            nz_reg <= ptc_pkg::NORMAL_Z_RESET;
            d_reg  <= ptc_pkg::OFFSET_RESET;
        end
        else if (cfg_valid)
        begin
            case (ptc_pkg::cfg_reg_t'(cfg_index))
                ptc_pkg::REG_NORMAL_X:     nx_reg <= cfg_data;
                ptc_pkg::REG_NORMAL_Y:     ny_reg <= cfg_data;
                ptc_pkg::REG_NORMAL_Z:     nz_reg <= cfg_data;
                ptc_pkg::REG_PLANE_OFFSET: d_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control: whole pipe advances together
    logic en;
    logic load;
    logic can_load;
    logic accept;

    assign in_stall = !en;
    assign accept   = in_valid && en;

    ptc_pkg::coord_t in_p [3][3];
    assign in_p[0][0] = first_x;
    assign in_p[0][1] = first_y;
    assign in_p[0][2] = first_z;
    assign in_p[1][0] = second_x;
    assign in_p[1][1] = second_y;
    assign in_p[1][2] = second_z;
    assign in_p[2][0] = third_x;
    assign in_p[2][1] = third_y;
    assign in_p[2][2] = third_z;

    // stage 1: products n_i * p_i
    logic                v1_reg;
    ptc_pkg::coord_t     p1_reg    [3][3];
    logic signed [63:0]  prod1_reg [3][3];
    logic signed [63:0]  prod1_next[3][3];

    always_comb
    begin
        for (int v = 0; v < 3; v++)
        begin
            prod1_next[v][0] = nx_reg * in_p[v][0];
            prod1_next[v][1] = ny_reg * in_p[v][1];
            prod1_next[v][2] = nz_reg * in_p[v][2];
        end
    end

    // stage 2: dot products
    logic                v2_reg;
    ptc_pkg::coord_t     p2_reg   [3][3];
    logic signed [65:0]  sum2_reg [3];

    // stage 3: side of plane
    logic                v3_reg;
    ptc_pkg::coord_t     p3_reg   [3][3];
    logic                kept3_reg[3];
    logic signed [63:0]  s3_reg   [3];
    logic signed [65:0]  d16;

    assign d16 = {{18{d_reg[31]}}, d_reg, 16'b0};

    // stage 4: polygon plan and divider operands
    ptc_pkg::ctx_t       ctx4_reg, ctx4_next;
    logic [63:0]         num4_reg [2], num4_next [2];
    logic [63:0]         den4_reg [2], den4_next [2];
    logic [1:0]          ia [2];
    logic [1:0]          ib [2];
    logic signed [63:0]  d14;

    assign d14 = {{18{d_reg[31]}}, d_reg, 14'b0};

    always_comb
    begin
        logic signed [32:0] delta;
        ctx4_next       = '0;
        ctx4_next.valid = v3_reg;
        ia[0] = 2'd0;
        ib[0] = 2'd0;
        ia[1] = 2'd0;
        ib[1] = 2'd0;
        ctx4_next.src = '{ptc_pkg::SRC_P0, ptc_pkg::SRC_P0, ptc_pkg::SRC_P0, ptc_pkg::SRC_P0};
        case ({kept3_reg[0], kept3_reg[1], kept3_reg[2]})
            3'b111:
            begin
                ctx4_next.cnt = 3'd3;
                ctx4_next.src = '{ptc_pkg::SRC_P0, ptc_pkg::SRC_P2, ptc_pkg::SRC_P1,
                                  ptc_pkg::SRC_P0};
            end
            3'b110:
            begin
                ctx4_next.cnt = 3'd4;
                ctx4_next.src = '{ptc_pkg::SRC_X1, ptc_pkg::SRC_X0, ptc_pkg::SRC_P1,
                                  ptc_pkg::SRC_P0};
                ia[0] = 2'd1; ib[0] = 2'd2; ia[1] = 2'd0; ib[1] = 2'd2;
            end
            3'b101:
            begin
                ctx4_next.cnt = 3'd4;
                ctx4_next.src = '{ptc_pkg::SRC_P2, ptc_pkg::SRC_X1, ptc_pkg::SRC_X0,
                                  ptc_pkg::SRC_P0};
                ia[0] = 2'd0; ib[0] = 2'd1; ia[1] = 2'd2; ib[1] = 2'd1;
            end
            3'b100:
            begin
                ctx4_next.cnt = 3'd3;
                ctx4_next.src = '{ptc_pkg::SRC_P0, ptc_pkg::SRC_X1, ptc_pkg::SRC_X0,
                                  ptc_pkg::SRC_P0};
                ia[0] = 2'd0; ib[0] = 2'd1; ia[1] = 2'd0; ib[1] = 2'd2;
            end
            3'b011:
            begin
                ctx4_next.cnt = 3'd4;
                ctx4_next.src = '{ptc_pkg::SRC_X1, ptc_pkg::SRC_P2, ptc_pkg::SRC_P1,
                                  ptc_pkg::SRC_X0};
                ia[0] = 2'd1; ib[0] = 2'd0; ia[1] = 2'd2; ib[1] = 2'd0;
            end
            3'b010:
            begin
                ctx4_next.cnt = 3'd3;
                ctx4_next.src = '{ptc_pkg::SRC_P0, ptc_pkg::SRC_X1, ptc_pkg::SRC_P1,
                                  ptc_pkg::SRC_X0};
                ia[0] = 2'd1; ib[0] = 2'd0; ia[1] = 2'd1; ib[1] = 2'd2;
            end
            3'b001:
            begin
                ctx4_next.cnt = 3'd3;
                ctx4_next.src = '{ptc_pkg::SRC_P0, ptc_pkg::SRC_P2, ptc_pkg::SRC_X1,
                                  ptc_pkg::SRC_X0};
                ia[0] = 2'd2; ib[0] = 2'd0; ia[1] = 2'd2; ib[1] = 2'd1;
            end
            default:
            begin
                // all vertices dropped: nothing is emitted
                ctx4_next.cnt = 3'd0;
            end
        endcase
        for (int v = 0; v < 3; v++)
            for (int i = 0; i < 3; i++)
                ctx4_next.p[v][i] = p3_reg[v][i];
        for (int c = 0; c < 2; c++)
        begin
            num4_next[c] = s3_reg[ia[c]] - d14;
            den4_next[c] = s3_reg[ia[c]] - s3_reg[ib[c]];
            for (int i = 0; i < 3; i++)
            begin
                ctx4_next.xa[c][i] = p3_reg[ia[c]][i];
                delta = 33'(p3_reg[ib[c]][i]) - 33'(p3_reg[ia[c]][i]);
                ctx4_next.neg[c][i] = delta[32];
                ctx4_next.mag[c][i] = delta[32] ? 33'(-delta) : 33'(delta);
            end
        end
    end

    // dividers run alongside the context line
    logic [32:0]   quo [2];
    ptc_pkg::ctx_t ctx_pipe_reg [DivDepth];

    for (genvar c = 0; c < 2; c++)
    begin : g_div
        ptc_div u_div (
            .clk (clk),
            .en  (en),
            .num (num4_reg[c]),
            .den (den4_reg[c]),
            .quo (quo[c])
        );
    end

    // stage 5: scale edge deltas by t
    ptc_pkg::ctx_t ctx5_reg;
    logic [65:0]   prod5_reg [2][3];

    // stage 6: crossing points and output group
    ptc_pkg::grp_t   grp6_reg, grp6_next;
    ptc_pkg::coord_t xp [2][3];

    always_comb
    begin
        logic [33:0]        off;
        logic signed [34:0] res;
        for (int c = 0; c < 2; c++)
            for (int i = 0; i < 3; i++)
            begin
                off = prod5_reg[c][i][65:32];
                if (ctx5_reg.neg[c][i])
                    res = 35'($signed(ctx5_reg.xa[c][i])) - $signed({1'b0, off});
                else
                    res = 35'($signed(ctx5_reg.xa[c][i])) + $signed({1'b0, off});
                if (res > 35'sh0_7FFF_FFFF)
                    xp[c][i] = 32'sh7FFF_FFFF;
                else if (res < -35'sh0_8000_0000)
                    xp[c][i] = 32'sh8000_0000;
                else
                    xp[c][i] = res[31:0];
            end
        grp6_next.valid = ctx5_reg.valid;
        grp6_next.cnt   = ctx5_reg.cnt;
        for (int k = 0; k < 4; k++)
        begin
            grp6_next.crossing[k] = 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                case (ctx5_reg.src[k])
                    ptc_pkg::SRC_P1: grp6_next.vtx[k][i] = ctx5_reg.p[1][i];
                    ptc_pkg::SRC_P2: grp6_next.vtx[k][i] = ctx5_reg.p[2][i];
                    ptc_pkg::SRC_X0: grp6_next.vtx[k][i] = xp[0][i];
                    ptc_pkg::SRC_X1: grp6_next.vtx[k][i] = xp[1][i];
                    default:         grp6_next.vtx[k][i] = ctx5_reg.p[0][i];
                endcase
            end
            grp6_next.crossing[k] = (ctx5_reg.src[k] == ptc_pkg::SRC_X0) ||
                                    (ctx5_reg.src[k] == ptc_pkg::SRC_X1);
        end
    end

    // valid bits and the context line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            ctx4_reg <= '0;
            for (int k = 0; k < DivDepth; k++)
                ctx_pipe_reg[k] <= '0;
            ctx5_reg <= '0;
            grp6_reg <= '0;
        end
        else if (en)
        begin
            v1_reg          <= accept;
            v2_reg          <= v1_reg;
            v3_reg          <= v2_reg;
            ctx4_reg        <= ctx4_next;
            ctx_pipe_reg[0] <= ctx4_reg;
            for (int k = 1; k < DivDepth; k++)
                ctx_pipe_reg[k] <= ctx_pipe_reg[k-1];
            ctx5_reg        <= ctx_pipe_reg[DivDepth-1];
            grp6_reg        <= grp6_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int v = 0; v < 3; v++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    p1_reg[v][i]    <= in_p[v][i];
                    prod1_reg[v][i] <= prod1_next[v][i];
                    p2_reg[v][i]    <= p1_reg[v][i];
                    p3_reg[v][i]    <= p2_reg[v][i];
                end
                sum2_reg[v]  <= 66'(prod1_reg[v][0]) + 66'(prod1_reg[v][1])
                              + 66'(prod1_reg[v][2]);
                kept3_reg[v] <= sum2_reg[v] > d16;
                s3_reg[v]    <= sum2_reg[v][65:2];
            end
            for (int c = 0; c < 2; c++)
            begin
                num4_reg[c] <= num4_next[c];
                den4_reg[c] <= den4_next[c];
            end
            for (int c = 0; c < 2; c++)
                for (int i = 0; i < 3; i++)
                    prod5_reg[c][i] <= ctx_pipe_reg[DivDepth-1].mag[c][i] * quo[c];
        end
    end

    // output sequencer: emit the loaded polygon one vertex at a time
    logic          busy_reg;
    logic [1:0]    idx_reg;
    ptc_pkg::grp_t buf_reg;
    logic          is_last;

    assign is_last  = (idx_reg == 2'(buf_reg.cnt - 3'd1));
    assign can_load = !busy_reg || (!out_stall && is_last);
    assign en       = !grp6_reg.valid || can_load;
    assign load     = grp6_reg.valid && can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else if (load)
        begin
            busy_reg <= (grp6_reg.cnt != 3'd0);
            idx_reg  <= 2'd0;
        end
        else if (busy_reg && !out_stall)
        begin
            if (is_last)
                busy_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            buf_reg <= grp6_reg;
    end

    assign out_valid    = busy_reg;
    assign vertex_x     = buf_reg.vtx[idx_reg][0];
    assign vertex_y     = buf_reg.vtx[idx_reg][1];
    assign vertex_z     = buf_reg.vtx[idx_reg][2];
    assign polygon_size = buf_reg.cnt;
    assign is_crossing  = buf_reg.crossing[idx_reg];
    assign last_vertex  = is_last;

endmodule

FILE: rtl/ptc_div.sv
// Pipelined restoring divider: fraction num/den in Q1.32, one quotient bit per stage.
module ptc_div (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] num,
    input  logic [63:0] den,
    output logic [32:0] quo
);

    localparam int Depth = ptc_pkg::QUO_W;

    logic [63:0]      rem_reg  [Depth];
    logic [63:0]      den_reg  [Depth];
    logic [Depth-1:0] q_reg    [Depth];
    logic             zero_reg [Depth];
    logic             full_reg [Depth];

    logic [63:0]      rem_next  [Depth];
    logic [Depth-1:0] q_next    [Depth];

    always_comb
    begin
        logic [63:0] r_sh;
        r_sh = {num[62:0], 1'b0};
        if (r_sh >= den)
        begin
            rem_next[0] = r_sh - den;
            q_next[0]   = Depth'(1);
        end
        else
        begin
            rem_next[0] = r_sh;
            q_next[0]   = '0;
        end
        for (int k = 1; k < Depth; k++)
        begin
            r_sh = {rem_reg[k-1][62:0], 1'b0};
            if (r_sh >= den_reg[k-1])
            begin
                rem_next[k] = r_sh - den_reg[k-1];
                q_next[k]   = {q_reg[k-1][Depth-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = r_sh;
                q_next[k]   = {q_reg[k-1][Depth-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= rem_next[0];
            q_reg[0]    <= q_next[0];
            den_reg[0]  <= den;
            zero_reg[0] <= (den == 64'd0);
            full_reg[0] <= (num == den) && (den != 64'd0);
            for (int k = 1; k < Depth; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                q_reg[k]    <= q_next[k];
                den_reg[k]  <= den_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
                full_reg[k] <= full_reg[k-1];
            end
        end
    end

    // equal differences give exactly one; a degenerate edge gives zero
    always_comb
    begin
        if (zero_reg[Depth-1])
            quo = '0;
        else if (full_reg[Depth-1])
            quo = {1'b1, {Depth{1'b0}}};
        else
            quo = {1'b0, q_reg[Depth-1]};
    end

endmodule
